// ----- hdl/mmae_pkg.sv -----
// Shared types and constants for the mouse motion accumulate and emit block.
`default_nettype none

package mmae_pkg;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;

    localparam logic       MODE_REPORT    = 1'b0;
    localparam logic       MODE_TICK      = 1'b1;
    localparam logic [5:0] MIN_REPORT_LEN = 6'd6;
    localparam logic [7:0] STEP_RESET     = 8'd37;
    localparam logic [4:0] BUTTON_MASK    = 5'h1F;
    localparam logic [3:0] HAT_CENTER     = 4'h8;
    localparam logic [7:0] CLAMP_MAX      = 8'sd127;
    localparam logic [7:0] CLAMP_MIN      = 8'h80;

    typedef struct packed {
        logic [7:0]         wheel;
        logic signed [15:0] dy;
        logic signed [15:0] dx;
        logic [5:0]         length;
    } report_t;

    typedef struct packed {
        logic [7:0] high_buttons;
        logic [7:0] hat_and_low_buttons;
        logic [7:0] y_byte;
        logic [7:0] x_byte;
        logic [7:0] sequence_byte;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/mouse_motion_accumulate_emit_top.sv -----
// Mouse motion accumulator and report emitter: accumulates reports, emits clamped reports on ticks.
//
// One request is taken every cycle while the skid is empty. A mouse report (s_tuser = 0) of
// at least six bytes adds its dx, dy and wheel to saturating accumulators and latches the low five
// button bits; it never gives a result. An emit tick (s_tuser = 1) clamps each motion accumulator
// to -128..127, keeps the remainder, clears the wheel accumulator and, unless it is still and
// unchanged after a still tick, gives one packed report on the master side. A tick's result is
// registered (in the skid if the output is held); a two-entry output (register plus skid) keeps
// s_tready high while one result waits, so the input side stalls only when two results are queued.
// Writes on the configuration channel set the sequence step and are always ready.
`default_nettype none

module mouse_motion_accumulate_emit_top
    import mmae_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [7:0]            cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // report_length[5:0], report_dx[21:6], report_dy[37:22], report_wheel[45:38],
    // report_buttons[53:46], zero fill [55:54]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // mode[0]
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // sequence_byte[7:0], x_byte[15:8], y_byte[23:16], hat_and_low_buttons[31:24],
    // high_buttons[39:32]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic [7:0]         step_reg;
    logic signed [31:0] accum_x_reg, accum_x_next;
    logic signed [31:0] accum_y_reg, accum_y_next;
    logic signed [15:0] accum_wheel_reg, accum_wheel_next;
    logic [4:0]         latched_buttons_reg, latched_buttons_next;
    logic [9:0]         previous_buttons_reg, previous_buttons_next;
    logic               previous_moving_reg, previous_moving_next;
    logic [7:0]         sequence_reg, sequence_next;

    logic               out_valid_reg;
    result_t            out_data_reg;
    logic               skid_valid_reg;
    result_t            skid_data_reg;

    report_t            rpt;
    logic [7:0]         rpt_buttons;
    logic               accept;
    logic               take;
    logic               emit;
    result_t            result;

    logic [32:0]        sum_x, sum_y;
    logic [16:0]        sum_wheel;
    logic [7:0]         clamp_x, clamp_y;
    logic [9:0]         word;
    logic               moving;

    assign rpt         = report_t'(s_tdata[45:0]);
    assign rpt_buttons = s_tdata[53:46];
    assign s_tready    = !skid_valid_reg;
    assign cfg_ready   = 1'b1;
    assign accept      = s_tvalid && s_tready;
    assign take        = m_tvalid && m_tready;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;

    always_comb
    begin
        sum_x     = {accum_x_reg[31], accum_x_reg} + {{17{rpt.dx[15]}}, rpt.dx};
        sum_y     = {accum_y_reg[31], accum_y_reg} + {{17{rpt.dy[15]}}, rpt.dy};
        sum_wheel = {accum_wheel_reg[15], accum_wheel_reg} + {{9{rpt.wheel[7]}}, rpt.wheel};

        if (!accum_x_reg[31] && (|accum_x_reg[30:7]))
            clamp_x = CLAMP_MAX;
        else if (accum_x_reg[31] && !(&accum_x_reg[30:7]))
            clamp_x = CLAMP_MIN;
        else
            clamp_x = accum_x_reg[7:0];

        if (!accum_y_reg[31] && (|accum_y_reg[30:7]))
            clamp_y = CLAMP_MAX;
        else if (accum_y_reg[31] && !(&accum_y_reg[30:7]))
            clamp_y = CLAMP_MIN;
        else
            clamp_y = accum_y_reg[7:0];

        word = {accum_wheel_reg[15],
                !accum_wheel_reg[15] && (|accum_wheel_reg[14:0]),
                3'b000, latched_buttons_reg};
        moving = (|clamp_x) || (|clamp_y) || (|accum_wheel_reg);

        accum_x_next          = accum_x_reg;
        accum_y_next          = accum_y_reg;
        accum_wheel_next      = accum_wheel_reg;
        latched_buttons_next  = latched_buttons_reg;
        previous_buttons_next = previous_buttons_reg;
        previous_moving_next  = previous_moving_reg;
        sequence_next         = sequence_reg;
        emit                  = 1'b0;

        if (accept)
        begin
            if (s_tuser == MODE_REPORT)
            begin
                if (rpt.length >= MIN_REPORT_LEN)
                begin
                    // saturate on signed overflow of the widened sum
                    if (sum_x[32] != sum_x[31])
                        accum_x_next = {sum_x[32], {31{!sum_x[32]}}};
                    else
                        accum_x_next = sum_x[31:0];
                    if (sum_y[32] != sum_y[31])
                        accum_y_next = {sum_y[32], {31{!sum_y[32]}}};
                    else
                        accum_y_next = sum_y[31:0];
                    if (sum_wheel[16] != sum_wheel[15])
                        accum_wheel_next = {sum_wheel[16], {15{!sum_wheel[16]}}};
                    else
                        accum_wheel_next = sum_wheel[15:0];
                    latched_buttons_next = rpt_buttons[4:0] & BUTTON_MASK;
                end
            end
            else
            begin
                accum_x_next     = accum_x_reg - {{24{clamp_x[7]}}, clamp_x};
                accum_y_next     = accum_y_reg - {{24{clamp_y[7]}}, clamp_y};
                accum_wheel_next = '0;
                if (moving || (word != previous_buttons_reg) || previous_moving_reg)
                begin
                    emit                  = 1'b1;
                    previous_buttons_next = word;
                    previous_moving_next  = moving;
                    sequence_next         = sequence_reg + step_reg;
                end
            end
        end

        result.sequence_byte       = sequence_next;
        result.x_byte              = {~clamp_x[7], clamp_x[6:0]};
        result.y_byte              = {~clamp_y[7], clamp_y[6:0]};
        result.hat_and_low_buttons = {word[3:0], HAT_CENTER};
        result.high_buttons        = {2'b00, word[9:4]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg             <= STEP_RESET;
            accum_x_reg          <= '0;
            accum_y_reg          <= '0;
            accum_wheel_reg      <= '0;
            latched_buttons_reg  <= '0;
            previous_buttons_reg <= '0;
            previous_moving_reg  <= 1'b0;
            sequence_reg         <= '0;
            out_valid_reg        <= 1'b0;
            skid_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                step_reg <= cfg_data;
            accum_x_reg          <= accum_x_next;
            accum_y_reg          <= accum_y_next;
            accum_wheel_reg      <= accum_wheel_next;
            latched_buttons_reg  <= latched_buttons_next;
            previous_buttons_reg <= previous_buttons_next;
            previous_moving_reg  <= previous_moving_next;
            sequence_reg         <= sequence_next;

            if (!out_valid_reg || take)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= emit;
                end
            end
            else if (emit)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (emit)
                out_data_reg <= result;
        end
        else if (emit)
        begin
            skid_data_reg <= result;
        end
    end

endmodule

`default_nettype wire
